>>> sv/ddpc_pkg.sv
// ----------------------------------------------------------------------------
// ddpc_pkg
// Shared types and constants for the digit dominated prefix count block.
// ----------------------------------------------------------------------------
package ddpc_pkg;

   localparam int RADIX_BITS = 16;
   localparam int LIMIT_BITS = 32;
   localparam int UPPER_BITS = 32;
   localparam int DOM_BITS   = 33;
   localparam int OTHER_BITS = 32;

   localparam logic [0:0] CSR_RADIX = 1'b0;
   localparam logic [0:0] CSR_LIMIT = 1'b1;

   // Controller commands to the datapath.
   typedef struct packed {
      logic load;      // capture operands, start digit split
      logic div_step;  // one restoring-division bit step
      logic div_end;   // store remainders, advance digit
      logic wt_mul;    // set walk position to digit count
      logic acc_mul;   // pick times weight, accumulate
      logic out_load;  // load the result register
   } dp_cmd_type;

   // Datapath status to the controller.
   typedef struct packed {
      logic div_last;  // last bit of the current division
      logic split_done;// both quotients are zero
      logic walk_done; // digit walk reached its end
      logic rsp_busy;  // result register occupied and not taken
   } dp_stat_type;

endpackage

>>> sv/ddpc_ctrl.sv
// ----------------------------------------------------------------------------
// ddpc_ctrl
// Controller that sequences the digit split and the digit walk.
// ----------------------------------------------------------------------------
module ddpc_ctrl
   import ddpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DIV  = 6'b000010,
      ST_DEND = 6'b000100,
      ST_WT   = 6'b001000,
      ST_ACC  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = ST_DEND;
         end
         ST_DEND: begin
            cmd.div_end = 1'b1;
            if (stat.split_done) state_in = ST_WT;
            else state_in = ST_DIV;
         end
         ST_WT: begin
            cmd.wt_mul = 1'b1;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_mul = 1'b1;
            if (stat.walk_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!stat.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> sv/ddpc_dpath.sv
// ----------------------------------------------------------------------------
// ddpc_dpath
// Datapath: bit-serial divider that splits y and m into digits, weight
// builder, and multiply-accumulate digit walk from the top digit down.
// ----------------------------------------------------------------------------
module ddpc_dpath
   import ddpc_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [0:0]            csr_index,
   input  logic [LIMIT_BITS-1:0] csr_data,
   input  logic [UPPER_BITS-1:0] req_upper_value,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [DOM_BITS-1:0]   rsp_dominated_count,
   output logic [OTHER_BITS-1:0] rsp_other_count,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat
);

   localparam int VB      = (VALUE_BITS < UPPER_BITS) ? VALUE_BITS : UPPER_BITS;
   localparam int ND      = VB;                 // radix >= 2 gives at most VB digits
   localparam int DW      = $clog2(ND);
   localparam int BW      = $clog2(VB);
   localparam int CW      = VB + 1;             // counts reach y + 1

   logic [RADIX_BITS-1:0] radix_ff;
   logic [LIMIT_BITS-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_BITS'(2);
         limit_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_RADIX) radix_ff <= csr_data[RADIX_BITS-1:0];
         else                        limit_ff <= csr_data;
      end
   end

   logic [RADIX_BITS-1:0] base;
   assign base = (radix_ff < RADIX_BITS'(2)) ? RADIX_BITS'(2) : radix_ff;

   // Digit stores: each entry written at a counter address and read at a
   // counter address, kept as plain registers with a digit count.
   logic [RADIX_BITS-1:0] yd_ff [ND];
   logic [RADIX_BITS-1:0] md_ff [ND];
   logic [VB-1:0]         yq_ff, mq_ff, y_ff;
   logic [RADIX_BITS:0]   yr_ff, mr_ff;
   logic [BW-1:0]         bit_ff;
   logic [DW:0]           nd_ff;     // digits produced
   logic [DW:0]           pos_ff;    // walk position + 1
   logic [CW-1:0]         wt_ff [ND];
   logic [CW-1:0]         wcur_ff;
   logic [CW-1:0]         acc_ff;
   logic                  stop_ff;
   logic                  rv_ff;
   logic [DOM_BITS-1:0]   dom_ff;
   logic [OTHER_BITS-1:0] oth_ff;

   // One restoring step for each operand.
   logic [RADIX_BITS:0] ytr, mtr;
   logic                yge, mge;
   assign ytr = {yr_ff[RADIX_BITS-1:0], yq_ff[VB-1]};
   assign mtr = {mr_ff[RADIX_BITS-1:0], mq_ff[VB-1]};
   assign yge = ytr >= {1'b0, base};
   assign mge = mtr >= {1'b0, base};

   // Walk digit selection.
   logic [DW-1:0]         wpos;
   logic [RADIX_BITS-1:0] yi, mi;
   logic [RADIX_BITS:0]   mi1, pick;
   logic [CW-1:0]         prod;
   logic [CW+RADIX_BITS:0] wprod;
   assign wpos = DW'(pos_ff - 1'b1);
   assign yi   = yd_ff[wpos];
   assign mi   = md_ff[wpos];
   assign mi1  = {1'b0, mi} + 1'b1;
   assign pick = ({1'b0, yi} < mi1) ? {1'b0, yi} : mi1;
   assign prod = CW'(pick * wt_ff[wpos]);
   // Weight of the next digit: current weight times (m digit just split + 1).
   assign wprod = wcur_ff * {1'b0, mr_ff[RADIX_BITS-1:0]} + {1'b0, wcur_ff};

   logic [CW-1:0] acc_next;
   logic          stop_next;
   assign acc_next  = acc_ff + prod;
   assign stop_next = yi > mi;

   assign stat.div_last   = (bit_ff == BW'(VB - 1));
   assign stat.split_done = (yq_ff == '0) && (mq_ff == '0);
   assign stat.walk_done  = stop_next || (pos_ff == (DW+1)'(1));
   assign stat.rsp_busy   = rv_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         yq_ff  <= req_upper_value[VB-1:0];
         y_ff   <= req_upper_value[VB-1:0];
         mq_ff  <= limit_ff[VB-1:0];
         yr_ff  <= '0;
         mr_ff  <= '0;
         bit_ff <= '0;
         nd_ff  <= '0;
         acc_ff <= '0;
         stop_ff <= 1'b0;
         wcur_ff <= CW'(1);
      end
      if (cmd.div_step) begin
         yr_ff  <= yge ? ytr - {1'b0, base} : ytr;
         mr_ff  <= mge ? mtr - {1'b0, base} : mtr;
         yq_ff  <= {yq_ff[VB-2:0], yge};
         mq_ff  <= {mq_ff[VB-2:0], mge};
         bit_ff <= bit_ff + 1'b1;
      end
      if (cmd.div_end) begin
         yd_ff[nd_ff[DW-1:0]] <= yr_ff[RADIX_BITS-1:0];
         md_ff[nd_ff[DW-1:0]] <= mr_ff[RADIX_BITS-1:0];
         wt_ff[nd_ff[DW-1:0]] <= wcur_ff;
         wcur_ff <= wprod[CW-1:0];
         nd_ff  <= nd_ff + 1'b1;
         yr_ff  <= '0;
         mr_ff  <= '0;
         bit_ff <= '0;
      end
      if (cmd.wt_mul) begin
         pos_ff <= nd_ff;
      end
      if (cmd.acc_mul) begin
         acc_ff  <= acc_next;
         stop_ff <= stop_next;
         if (!stop_next) pos_ff <= pos_ff - 1'b1;
      end
   end

   // Result: add one when the walk never stopped.
   logic [CW-1:0] hit;
   logic [CW-1:0] y1;
   assign hit = stop_ff ? acc_ff : acc_ff + CW'(1);
   assign y1  = {1'b0, y_ff} + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rv_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rv_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         dom_ff <= DOM_BITS'(hit);
         oth_ff <= OTHER_BITS'(y1 - hit);
      end
   end

   assign rsp_valid           = rv_ff;
   assign rsp_dominated_count = dom_ff;
   assign rsp_other_count     = oth_ff;

endmodule

>>> sv/digit_dominated_prefix_count_top.sv
// ----------------------------------------------------------------------------
// digit_dominated_prefix_count_top
// Counts x in 0..y whose base-p digits are all at most those of a limit m.
// ----------------------------------------------------------------------------
// Usage:
// The csr_ port writes radix (index 0) and limit_value (index 1); write
// only while no transaction is in flight. A radix of 0 or 1 acts as 2.
// A req_ transaction carries upper value y; one rsp_ transaction follows
// with the dominated count and its complement (y + 1) minus that count.
// Operation: each digit comes from the bit-serial restoring divider, which
// splits both operands in parallel (ST_DIV steps, then ST_DEND) and builds
// the digit weights; the multiply-accumulate pass then walks the digits
// from the top down. One transaction is processed at a time, so req_stall
// stays high from acceptance until the result is loaded.
// The result sits in an output register; a new request is taken while it
// waits for the receiver. If rsp_stall holds, the next result waits in the
// controller until the register frees. Reset returns radix to 2, limit to
// 0 and drops all pending work.
// ----------------------------------------------------------------------------
module digit_dominated_prefix_count_top
   import ddpc_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [0:0]            csr_index,
   input  logic [LIMIT_BITS-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [UPPER_BITS-1:0] req_upper_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DOM_BITS-1:0]   rsp_dominated_count,
   output logic [OTHER_BITS-1:0] rsp_other_count
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequencer for split, weight and walk phases.
   ddpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Registers, divider, digit stores and accumulator.
   ddpc_dpath #(.VALUE_BITS(VALUE_BITS)) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_upper_value     (req_upper_value),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_dominated_count (rsp_dominated_count),
      .rsp_other_count     (rsp_other_count),
      .cmd                 (cmd),
      .stat                (stat)
   );

`ifndef SYNTHESIS
   // A result is only loaded when the output register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid && rsp_stall))
      else $error("result register overwritten");
   // A valid result never carries a dominated count of zero.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dominated_count != '0)
      else $error("dominated count zero");
   // A new request is never taken while the datapath is busy.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item accepted");
`endif

endmodule

>>> bench/ddpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpc_checker
// Watches the request, response and register ports of the digit dominated
// prefix count block, computes the expected counts and compares them.
// ----------------------------------------------------------------------------
module ddpc_checker
   import ddpc_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [0:0]            csr_index,
   input  logic [LIMIT_BITS-1:0] csr_data,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [UPPER_BITS-1:0] req_upper_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [DOM_BITS-1:0]   rsp_dominated_count,
   input  logic [OTHER_BITS-1:0] rsp_other_count,
   output int                    fail_count,
   output int                    pending_count,
   output int                    result_count
);

   typedef struct packed {
      logic [DOM_BITS-1:0]   dominated;
      logic [OTHER_BITS-1:0] other;
   } count_pair_type;

   logic [RADIX_BITS-1:0] radix_q;
   logic [LIMIT_BITS-1:0] limit_q;
   count_pair_type        pending_counts[$];

   // Lucas digit-dominance count of x in 0..y against limit m in base p.
   function automatic count_pair_type lucas_counts(input logic [RADIX_BITS-1:0] p_raw,
                                                   input logic [LIMIT_BITS-1:0] m_raw,
                                                   input logic [UPPER_BITS-1:0] y_raw);
      logic [63:0] base, mask, y, m, yv, mv, acc, pick;
      logic [63:0] yd[64];
      logic [63:0] md[64];
      logic [63:0] wt[64];
      int          ny, nm, len, pos;
      bit          stopped;
      count_pair_type res;
      base = (p_raw < 2) ? 64'd2 : 64'(p_raw);
      mask = (64'd1 << VALUE_BITS) - 1;
      y = 64'(y_raw) & mask;
      m = 64'(m_raw) & mask;
      for (int i = 0; i < 64; i++) begin
         yd[i] = 0;
         md[i] = 0;
      end
      ny = 0;
      nm = 0;
      yv = y;
      mv = m;
      while (yv > 0) begin
         yd[ny] = yv % base;
         yv = yv / base;
         ny++;
      end
      while (mv > 0) begin
         md[nm] = mv % base;
         mv = mv / base;
         nm++;
      end
      if (ny == 0) ny = 1;
      if (nm == 0) nm = 1;
      len = (ny > nm) ? ny : nm;
      wt[0] = 1;
      for (int i = 1; i < len; i++) wt[i] = wt[i-1] * (md[i-1] + 1);
      acc = 0;
      stopped = 0;
      for (pos = len - 1; pos >= 0 && !stopped; pos--) begin
         pick = (yd[pos] < md[pos] + 1) ? yd[pos] : md[pos] + 1;
         acc += pick * wt[pos];
         if (yd[pos] > md[pos]) stopped = 1;
      end
      if (!stopped) acc += 1;
      res.dominated = acc[DOM_BITS-1:0];
      res.other = 32'((y + 1) - acc);
      return res;
   endfunction

   always @(posedge clock) begin
      count_pair_type exp_pair;
      if (reset) begin
         radix_q        <= 16'd2;
         limit_q        <= '0;
         fail_count     <= 0;
         result_count   <= 0;
         pending_counts.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_RADIX) radix_q <= csr_data[RADIX_BITS-1:0];
            else if (csr_index == CSR_LIMIT) limit_q <= csr_data;
         end
         if (req_valid && !req_stall)
            pending_counts.insert(pending_counts.size(),
                                  lucas_counts(radix_q, limit_q, req_upper_value));
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (pending_counts.size() == 0) begin
               $error("Response transaction arrived with no request outstanding.");
               fail_count <= fail_count + 1;
            end else begin
               exp_pair = pending_counts.pop_front();
               if (rsp_dominated_count !== exp_pair.dominated ||
                   rsp_other_count !== exp_pair.other)
                  fail_count <= fail_count + 1;
               if (rsp_dominated_count !== exp_pair.dominated)
                  $error("dominated_count expected %0d got %0d",
                         exp_pair.dominated, rsp_dominated_count);
               if (rsp_other_count !== exp_pair.other)
                  $error("other_count expected %0d got %0d",
                         exp_pair.other, rsp_other_count);
            end
         end
      end
      pending_count = pending_counts.size();
   end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the digit dominated prefix count block.
// ----------------------------------------------------------------------------
// Directed values, then random phases under several radix and limit
// settings, with idle and stall patterns on both channels. The checker
// beside the block predicts every response and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top
   import ddpc_pkg::*;
();

   localparam int VALUE_BITS  = 32;
   localparam int DRAIN_WAIT  = 1300;   // a bit above the worst-case latency
   localparam int WATCH_LIMIT = 40000;  // cycles without any transaction

   logic                  clock;
   logic                  reset;
   logic                  csr_write;
   logic [0:0]            csr_index;
   logic [LIMIT_BITS-1:0] csr_data;
   logic                  req_valid;
   logic                  req_stall;
   logic [UPPER_BITS-1:0] req_upper_value;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [DOM_BITS-1:0]   rsp_dominated_count;
   logic [OTHER_BITS-1:0] rsp_other_count;

   int fail_count, pending_count, result_count;
   int sent_count;
   int send_idle_pct;     // chance per cycle that the sender stays idle
   int stall_pct;         // chance per cycle that the receiver stalls
   bit hold_off;          // long receiver hold-off requested
   int idle_stalls;

   digit_dominated_prefix_count_top #(.VALUE_BITS(VALUE_BITS)) u_top (.*);

   ddpc_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: random stalls, or a long counted hold-off when asked.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (4000) @(negedge clock);
            hold_off = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Watchdog: ends the run if no transaction moves for too long.
   initial begin
      idle_stalls = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
            idle_stalls = 0;
         else if (++idle_stalls >= WATCH_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // Offer one request transaction, idling first as the phase asks.
   // Valid stays up after acceptance until the next call or a drain.
   task automatic send_upper(input logic [UPPER_BITS-1:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_upper_value <= y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   // Wait until every response is in, then for the block to settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [LIMIT_BITS-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Random upper value: full-range, small, near the limit, edge, or masked by the limit.
   function automatic logic [UPPER_BITS-1:0] pick_upper(input logic [LIMIT_BITS-1:0] m);
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(255);
         2: return m + $urandom_range(64) - 32;
         3: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
         default: return $urandom & m;
      endcase
   endfunction

   initial begin
      logic [RADIX_BITS-1:0] radix_set[7];
      logic [LIMIT_BITS-1:0] limit_set;
      logic [UPPER_BITS-1:0] directed_y[10];
      radix_set  = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd10, 16'd65535, 16'd7};
      directed_y = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd7, 32'd8,
                     32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd100};
      reset           = 1'b1;
      csr_write       = 1'b0;
      csr_index       = CSR_RADIX;
      csr_data        = '0;
      req_valid       = 1'b0;
      req_upper_value = '0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      hold_off        = 1'b0;
      sent_count      = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset settings (radix 2, limit 0), then extremes.
      foreach (directed_y[i]) send_upper(directed_y[i]);
      drain();
      write_reg(CSR_RADIX, 32'd65535);
      write_reg(CSR_LIMIT, 32'hFFFF_FFFF);
      foreach (directed_y[i]) send_upper(directed_y[i]);
      drain();
      write_reg(CSR_RADIX, 32'd1);
      write_reg(CSR_LIMIT, 32'h0000_00B5);
      for (int i = 0; i < 4; i++) send_upper(directed_y[i]);
      drain();

      // Random phases; each phase picks new registers and an idling pattern.
      for (int phase = 0; phase < 16; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 79; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 79; end
            default: begin send_idle_pct = 27; stall_pct = 27; end
         endcase
         limit_set = (phase % 5 == 0) ? 32'hFFFF_FFFF :
                     (phase % 5 == 1) ? 32'h0 : $urandom;
         write_reg(CSR_RADIX, (phase < 7) ? 32'(radix_set[phase]) :
                                            32'($urandom_range(2, 40)));
         write_reg(CSR_LIMIT, limit_set);
         // Long receiver hold-off while requests keep coming, once.
         if (phase == 4) hold_off = 1'b1;
         for (int k = 0; k < 30; k++) send_upper(pick_upper(limit_set));
         drain();  // sender pauses until all responses have come back
      end

      $display("Run covered %0d requests and %0d responses over 19 register settings,",
               sent_count, result_count);
      $display("including radix 0, 1, 2, 65535 and limits 0 and all ones.");
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
